// ===== design/wtsp_pkg.sv =====
// shared types, constants and helpers for the world-to-screen projection pipeline
package wtsp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int BASIS_W     = 18;
    localparam int BASIS_FRAC  = 16;
    localparam int FOCAL_W     = 32;
    localparam int SIZE_W      = 16;
    localparam int CFG_W       = 3 * BASIS_W;
    localparam int CFG_IDX_W   = 3;

    // derived datapath widths
    localparam int D_W    = COORD_WIDTH + 1;
    localparam int PROD_W = D_W + BASIS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CAM_W  = SUM_W - BASIS_FRAC;
    localparam int DVD_W  = FOCAL_W + FRAC_BITS;
    localparam int MUL_W  = 2 * COORD_WIDTH;
    localparam int SCL_W  = MUL_W - FRAC_BITS;
    localparam int SCR_W  = ((SCL_W > SIZE_W + FRAC_BITS) ? SCL_W : SIZE_W + FRAC_BITS) + 2;

    localparam int CAM_LAT = 3;
    localparam int SCR_LAT = 3;
    localparam int LATENCY = CAM_LAT + DVD_W + SCR_LAT;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_U     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_V     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_N     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_DEPTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 3'd7;

    // reset values
    localparam logic [COORD_WIDTH-1:0] RST_POS_Z  = COORD_WIDTH'(5) << FRAC_BITS;
    localparam logic [CFG_W-1:0]       RST_BASIS_U = 54'd196608;
    localparam logic [CFG_W-1:0]       RST_BASIS_V = 54'd17179869184;
    localparam logic [CFG_W-1:0]       RST_BASIS_N = 54'd4503599627370496;
    localparam logic [FOCAL_W-1:0]     RST_FOCAL   = 32'd22702339;
    localparam logic [2*SIZE_W-1:0]    RST_IMAGE   = 32'd26214800;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] screen_x;
        logic signed [COORD_WIDTH-1:0] screen_y;
        logic        [COORD_WIDTH-1:0] recip_depth;
        logic                          behind;
    } t_screen;

    // data that rides alongside the divider
    typedef struct packed {
        logic                          behind;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } t_side;

    function automatic logic signed [COORD_WIDTH-1:0] sat_cam(
        input logic signed [CAM_W-1:0] v
    );
        logic [CAM_W-COORD_WIDTH:0] top;
        top = v[CAM_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[CAM_W-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_scr(
        input logic signed [SCR_W-1:0] v
    );
        logic [SCR_W-COORD_WIDTH:0] top;
        top = v[SCR_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[SCR_W-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

// ===== design/wtsp_camera.sv =====
// camera-space transform: offset, basis products, dot sums and depth test
module wtsp_camera (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  wtsp_pkg::t_point                i_point,
    input  logic [wtsp_pkg::COORD_WIDTH-1:0] i_pos_x,
    input  logic [wtsp_pkg::COORD_WIDTH-1:0] i_pos_y,
    input  logic [wtsp_pkg::COORD_WIDTH-1:0] i_pos_z,
    input  logic [wtsp_pkg::CFG_W-1:0]      i_basis_u,
    input  logic [wtsp_pkg::CFG_W-1:0]      i_basis_v,
    input  logic [wtsp_pkg::CFG_W-1:0]      i_basis_n,
    output logic                            o_valid,
    output logic [wtsp_pkg::CAM_W-1:0]      o_divisor,
    output wtsp_pkg::t_side                 o_side
);
    import wtsp_pkg::*;

    logic                     r_vld1, r_vld2, r_vld3;
    logic signed [D_W-1:0]    r_d [3];
    logic signed [PROD_W-1:0] r_prod [9];
    logic [CFG_W-1:0]         basis [3];
    logic [CAM_W-1:0]         r_div;
    t_side                    r_side;

    logic signed [SUM_W-1:0]  sum [3];
    logic signed [CAM_W-1:0]  cam [3];

    assign basis[0] = i_basis_u;
    assign basis[1] = i_basis_v;
    assign basis[2] = i_basis_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= D_W'(i_point.point_x) - D_W'($signed(i_pos_x));
        r_d[1] <= D_W'(i_point.point_y) - D_W'($signed(i_pos_y));
        r_d[2] <= D_W'(i_point.point_z) - D_W'($signed(i_pos_z));
    end

    // row b, column j: d_j times component j of basis b
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 3; b++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[3*b+j] <= PROD_W'(r_d[j]) *
                                 PROD_W'($signed(basis[b][BASIS_W*j +: BASIS_W]));
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            sum[b] = SUM_W'(r_prod[3*b]) + SUM_W'(r_prod[3*b+1]) + SUM_W'(r_prod[3*b+2]);
            // arithmetic shift gives rounding toward minus infinity
            cam[b] = sum[b][SUM_W-1:BASIS_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side.cx     <= sat_cam(cam[0]);
        r_side.cy     <= sat_cam(cam[1]);
        // in front only when cz is strictly negative
        r_side.behind <= !cam[2][CAM_W-1];
        r_div         <= CAM_W'(-cam[2]);
    end

    assign o_valid   = r_vld3;
    assign o_divisor = r_div;
    assign o_side    = r_side;

endmodule

// ===== design/wtsp_divider.sv =====
// restoring divider, one quotient bit per pipeline stage
module wtsp_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wtsp_pkg::DVD_W-1:0]  i_dividend,
    input  logic [wtsp_pkg::CAM_W-1:0]  i_divisor,
    input  wtsp_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [wtsp_pkg::DVD_W-1:0]  o_quot,
    output wtsp_pkg::t_side             o_side
);
    import wtsp_pkg::*;

    logic              r_vld [DVD_W];
    logic [CAM_W-1:0]  r_rem [DVD_W];
    logic [CAM_W-1:0]  r_div [DVD_W];
    logic [DVD_W-1:0]  r_dvd [DVD_W];
    logic [DVD_W-1:0]  r_quo [DVD_W];
    t_side             r_sd  [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic              pv;
        logic [CAM_W-1:0]  prem, pdiv;
        logic [DVD_W-1:0]  pdvd, pquo;
        t_side             psd;
        logic [CAM_W:0]    trial, diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign pv   = i_valid;
            assign prem = '0;
            assign pdiv = i_divisor;
            assign pdvd = i_dividend;
            assign pquo = '0;
            assign psd  = i_side;
        end else begin : g_next
            assign pv   = r_vld[k-1];
            assign prem = r_rem[k-1];
            assign pdiv = r_div[k-1];
            assign pdvd = r_dvd[k-1];
            assign pquo = r_quo[k-1];
            assign psd  = r_sd[k-1];
        end

        assign trial = {prem, pdvd[DVD_W-1]};
        assign diff  = trial - {1'b0, pdiv};
        assign ge    = trial >= {1'b0, pdiv};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[CAM_W-1:0] : trial[CAM_W-1:0];
            r_div[k] <= pdiv;
            r_dvd[k] <= {pdvd[DVD_W-2:0], 1'b0};
            r_quo[k] <= {pquo[DVD_W-2:0], ge};
            r_sd[k]  <= psd;
        end
    end

    assign o_valid = r_vld[DVD_W-1];
    assign o_quot  = r_quo[DVD_W-1];
    assign o_side  = r_sd[DVD_W-1];

endmodule

// ===== design/wtsp_screen.sv =====
// screen mapping: depth clamp, scaled products, centre offset and saturation
module wtsp_screen (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [wtsp_pkg::DVD_W-1:0]       i_quot,
    input  wtsp_pkg::t_side                  i_side,
    input  logic [2*wtsp_pkg::SIZE_W-1:0]    i_image_size,
    output logic                             o_valid,
    output wtsp_pkg::t_screen                o_result
);
    import wtsp_pkg::*;

    logic                   r_vla, r_vlb, r_vlc;
    logic [COORD_WIDTH-1:0] r_rhw_a, r_magx, r_magy, r_rhw_b;
    logic                   r_sgx_a, r_sgy_a, r_sgx_b, r_sgy_b, r_beh_a, r_beh_b;
    logic [MUL_W-1:0]       r_px, r_py;
    t_screen                r_res;

    logic signed [SCR_W-1:0] tx, ty, cen_x, cen_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vla <= 1'b0;
            r_vlb <= 1'b0;
            r_vlc <= 1'b0;
        end else begin
            r_vla <= i_valid;
            r_vlb <= r_vla;
            r_vlc <= r_vlb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rhw_a <= (|i_quot[DVD_W-1:COORD_WIDTH]) ? '1 : i_quot[COORD_WIDTH-1:0];
        r_magx  <= i_side.cx[COORD_WIDTH-1] ? COORD_WIDTH'(-i_side.cx) : i_side.cx;
        r_magy  <= i_side.cy[COORD_WIDTH-1] ? COORD_WIDTH'(-i_side.cy) : i_side.cy;
        r_sgx_a <= i_side.cx[COORD_WIDTH-1];
        r_sgy_a <= i_side.cy[COORD_WIDTH-1];
        r_beh_a <= i_side.behind;
    end

    always_ff @(posedge i_clk) begin
        r_px    <= MUL_W'(r_rhw_a) * MUL_W'(r_magx);
        r_py    <= MUL_W'(r_rhw_a) * MUL_W'(r_magy);
        r_rhw_b <= r_rhw_a;
        r_sgx_b <= r_sgx_a;
        r_sgy_b <= r_sgy_a;
        r_beh_b <= r_beh_a;
    end

    // truncation on the magnitude rounds toward zero
    always_comb begin
        tx    = SCR_W'(r_px[MUL_W-1:FRAC_BITS]);
        ty    = SCR_W'(r_py[MUL_W-1:FRAC_BITS]);
        cen_x = SCR_W'({i_image_size[SIZE_W-1:0], {(FRAC_BITS-1){1'b0}}});
        cen_y = SCR_W'({i_image_size[2*SIZE_W-1:SIZE_W], {(FRAC_BITS-1){1'b0}}});
        if (r_sgx_b) begin
            tx = -tx;
        end
        if (r_sgy_b) begin
            ty = -ty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_beh_b) begin
            r_res.screen_x    <= '0;
            r_res.screen_y    <= '0;
            r_res.recip_depth <= '0;
            r_res.behind      <= 1'b1;
        end else begin
            r_res.screen_x    <= sat_scr(cen_x + tx);
            r_res.screen_y    <= sat_scr(cen_y - ty);
            r_res.recip_depth <= r_rhw_b;
            r_res.behind      <= 1'b0;
        end
    end

    assign o_valid  = r_vlc;
    assign o_result = r_res;

endmodule

// ===== design/world_to_screen_projection.sv =====
// top level of the world-to-screen projection pipeline
// Projects one world-space point per clock: a point taken on start comes out on
// o_valid/o_result after passing through the pipeline (3 camera-transform stages,
// 48 stages of a bit-per-stage restoring divider for focal_depth / -cz, and 3
// screen-mapping stages). busy is never raised, so a new transaction can be
// issued every cycle; the result is shown for one cycle and must be taken then.
// Points with cz >= 0 return behind = 1 and zero coordinates. Registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data and should only change while
// the pipeline is empty.
module world_to_screen_projection (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  wtsp_pkg::t_point                 i_point,
    input  logic                             i_cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wtsp_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output wtsp_pkg::t_screen                o_result
);
    import wtsp_pkg::*;

    logic [COORD_WIDTH-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [CFG_W-1:0]       r_basis_u, r_basis_v, r_basis_n;
    logic [FOCAL_W-1:0]     r_focal;
    logic [2*SIZE_W-1:0]    r_image;

    logic                   cam_valid, div_valid;
    logic [CAM_W-1:0]       cam_divisor;
    t_side                  cam_side, div_side;
    logic [DVD_W-1:0]       div_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= RST_POS_Z;
            r_basis_u <= RST_BASIS_U;
            r_basis_v <= RST_BASIS_V;
            r_basis_n <= RST_BASIS_N;
            r_focal   <= RST_FOCAL;
            r_image   <= RST_IMAGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POS_X: begin
                    r_pos_x <= i_cfg_data[COORD_WIDTH-1:0];
                end
                REG_POS_Y: begin
                    r_pos_y <= i_cfg_data[COORD_WIDTH-1:0];
                end
                REG_POS_Z: begin
                    r_pos_z <= i_cfg_data[COORD_WIDTH-1:0];
                end
                REG_BASIS_U: begin
                    r_basis_u <= i_cfg_data;
                end
                REG_BASIS_V: begin
                    r_basis_v <= i_cfg_data;
                end
                REG_BASIS_N: begin
                    r_basis_n <= i_cfg_data;
                end
                REG_FOCAL_DEPTH: begin
                    r_focal <= i_cfg_data[FOCAL_W-1:0];
                end
                REG_IMAGE_SIZE: begin
                    r_image <= i_cfg_data[2*SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    wtsp_camera u_camera (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_point   (i_point),
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_pos_z   (r_pos_z),
        .i_basis_u (r_basis_u),
        .i_basis_v (r_basis_v),
        .i_basis_n (r_basis_n),
        .o_valid   (cam_valid),
        .o_divisor (cam_divisor),
        .o_side    (cam_side)
    );

    wtsp_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (cam_valid),
        .i_dividend ({r_focal, {FRAC_BITS{1'b0}}}),
        .i_divisor  (cam_divisor),
        .i_side     (cam_side),
        .o_valid    (div_valid),
        .o_quot     (div_quot),
        .o_side     (div_side)
    );

    wtsp_screen u_screen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (div_valid),
        .i_quot       (div_quot),
        .i_side       (div_side),
        .i_image_size (r_image),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

endmodule

// ===== design/wtsp_checker.sv =====
// port-level checks for the projection pipeline, bound to the top level
module wtsp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_valid,
    input  wtsp_pkg::t_screen o_result
);
    import wtsp_pkg::*;

    // every accepted transaction comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted transaction gave no result");

    // no result without a matching transaction
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a transaction");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.behind) |->
            (o_result.screen_x == 0 && o_result.screen_y == 0 &&
             o_result.recip_depth == 0))
        else $error("behind result carries coordinates");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the world-to-screen projection pipeline
`timescale 1ns / 1ps

module testbench;
    import wtsp_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_point               i_point;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    t_screen              o_result;

    world_to_screen_projection uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point    (i_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // local copy of the camera registers
    logic [COORD_WIDTH-1:0] cam_pos_x, cam_pos_y, cam_pos_z;
    logic [CFG_W-1:0]       cam_u, cam_v, cam_n;
    logic [FOCAL_W-1:0]     cam_focal;
    logic [2*SIZE_W-1:0]    cam_size;

    t_screen screens_due[$];
    int      n_errors   = 0;
    int      n_checked  = 0;
    int      n_behind   = 0;
    int      n_sent     = 0;
    int      gap_pct    = 0;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint floor_q16(input longint v);
        return v >>> BASIS_FRAC;
    endfunction

    function automatic longint clamp_coord(input longint v);
        longint hi;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint basis_dot(input longint dx, input longint dy,
                                         input longint dz, input logic [CFG_W-1:0] b);
        longint bx, by, bz;
        bx = longint'($signed(b[BASIS_W-1:0]));
        by = longint'($signed(b[2*BASIS_W-1:BASIS_W]));
        bz = longint'($signed(b[3*BASIS_W-1:2*BASIS_W]));
        return floor_q16(dx * bx + dy * by + dz * bz);
    endfunction

    // (rhw * c) >> FRAC_BITS toward zero; rhw and |c| fit 32 bits so no overflow
    function automatic longint scaled_product(input longint rhw, input longint c);
        longint mag;
        mag = (c < 0) ? -c : c;
        mag = longint'((longint'(rhw) * mag) >>> FRAC_BITS);
        if (mag < 0) mag = longint'(1) <<< 62;
        return (c < 0) ? -mag : mag;
    endfunction

    function automatic t_screen project_point(input t_point p);
        t_screen r;
        longint dx, dy, dz, cx, cy, cz, rhw, sx, sy;
        logic [63:0] num;
        dx = longint'(p.point_x) - longint'($signed(cam_pos_x));
        dy = longint'(p.point_y) - longint'($signed(cam_pos_y));
        dz = longint'(p.point_z) - longint'($signed(cam_pos_z));
        cx = clamp_coord(basis_dot(dx, dy, dz, cam_u));
        cy = clamp_coord(basis_dot(dx, dy, dz, cam_v));
        cz = basis_dot(dx, dy, dz, cam_n);
        r = '0;
        if (-cz <= 0) begin
            r.behind = 1'b1;
            return r;
        end
        num = {16'd0, cam_focal, 16'd0};
        rhw = longint'(num / 64'(-cz));
        if (rhw > 64'hFFFF_FFFF) rhw = 64'hFFFF_FFFF;
        sx = clamp_coord(longint'({cam_size[15:0], 15'd0}) + scaled_product(rhw, cx));
        sy = clamp_coord(longint'({cam_size[31:16], 15'd0}) - scaled_product(rhw, cy));
        r.screen_x    = sx[COORD_WIDTH-1:0];
        r.screen_y    = sy[COORD_WIDTH-1:0];
        r.recip_depth = rhw[COORD_WIDTH-1:0];
        return r;
    endfunction

    // checker: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_screen want;
        if (i_rst_n && o_valid) begin
            if (screens_due.size() == 0) begin
                $error("unexpected result transaction %h", o_result);
                n_errors++;
            end else begin
                want = screens_due.pop_front();
                n_checked++;
                if (want.behind) n_behind++;
                if (o_result.screen_x !== want.screen_x) begin
                    $error("screen_x expected %h got %h", want.screen_x, o_result.screen_x);
                    n_errors++;
                end
                if (o_result.screen_y !== want.screen_y) begin
                    $error("screen_y expected %h got %h", want.screen_y, o_result.screen_y);
                    n_errors++;
                end
                if (o_result.recip_depth !== want.recip_depth) begin
                    $error("recip_depth expected %h got %h",
                           want.recip_depth, o_result.recip_depth);
                    n_errors++;
                end
                if (o_result.behind !== want.behind) begin
                    $error("behind expected %b got %b", want.behind, o_result.behind);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_point(input t_point p);
        // random gap before the transaction, start stays high when none
        if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        screens_due.push_back(project_point(p));
        n_sent++;
    endtask

    task automatic drain_pipe;
        start <= 1'b0;
        @(posedge i_clk);
        while (screens_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_POS_X:       cam_pos_x = val[COORD_WIDTH-1:0];
            REG_POS_Y:       cam_pos_y = val[COORD_WIDTH-1:0];
            REG_POS_Z:       cam_pos_z = val[COORD_WIDTH-1:0];
            REG_BASIS_U:     cam_u     = val;
            REG_BASIS_V:     cam_v     = val;
            REG_BASIS_N:     cam_n     = val;
            REG_FOCAL_DEPTH: cam_focal = val[FOCAL_W-1:0];
            REG_IMAGE_SIZE:  cam_size  = val[2*SIZE_W-1:0];
            default: begin
            end
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pack_basis(input int x, input int y, input int z);
        return {18'(z), 18'(y), 18'(x)};
    endfunction

    function automatic logic [31:0] rand_word;
        // favour extremes and small values alongside the full range
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000 + $urandom_range(3, 0);
            1: return 32'h7FFF_FFFF - $urandom_range(3, 0);
            2: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_point rand_point(input bit near);
        t_point p;
        if (near) begin
            p.point_x = 32'($signed($urandom_range(1 << 22, 0)) - (1 << 21));
            p.point_y = 32'($signed($urandom_range(1 << 22, 0)) - (1 << 21));
            p.point_z = 32'($signed($urandom_range(1 << 23, 0)) - (1 << 22));
        end else begin
            p.point_x = rand_word();
            p.point_y = rand_word();
            p.point_z = rand_word();
        end
        return p;
    endfunction

    task automatic test_reset_camera;
        t_point p;
        p = '{0, 0, 0};
        send_point(p);
        p = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
        send_point(p);
        p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_point(p);
        p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_point(p);
        // point exactly on the camera plane and one just in front of it
        p = '{32'sh0002_0000, 32'sh0000_0000, 32'sh0005_0000};
        send_point(p);
        p = '{32'sh0002_0000, 32'sh0000_0000, 32'sh0004_FFFF};
        send_point(p);
        p = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0005_0001};
        send_point(p);
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000};
        send_point(p);
        p = '{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA};
        send_point(p);
        drain_pipe();
    endtask

    task automatic test_extreme_camera;
        t_point p;
        write_reg(REG_POS_X, 54'h3F_FFFF_8000_0000);
        write_reg(REG_POS_Y, 54'h7FFF_FFFF);
        write_reg(REG_POS_Z, 54'h7FFF_FFFF);
        write_reg(REG_BASIS_U, pack_basis(131071, -131072, 131071));
        write_reg(REG_BASIS_V, pack_basis(-131072, 131071, -131072));
        write_reg(REG_BASIS_N, pack_basis(-131072, -131072, 131071));
        write_reg(REG_FOCAL_DEPTH, 54'hFFFF_FFFF);
        write_reg(REG_IMAGE_SIZE, 54'hFFFF_FFFF);
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
        send_point(p);
        p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_point(p);
        p = '{0, 0, 0};
        send_point(p);
        p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_point(p);
        drain_pipe();
        // zero focal depth puts everything on the centre
        write_reg(REG_FOCAL_DEPTH, '0);
        write_reg(REG_IMAGE_SIZE, '0);
        write_reg(REG_BASIS_N, pack_basis(0, 0, 65536));
        write_reg(REG_POS_X, '0);
        write_reg(REG_POS_Y, '0);
        write_reg(REG_POS_Z, '0);
        p = '{32'sh0003_0000, 32'shFFFD_0000, 32'shFFF0_0000};
        send_point(p);
        p = '{32'sh0000_0000, 32'sh0000_0000, 32'shFFFF_FFFF};
        send_point(p);
        drain_pipe();
    endtask

    task automatic test_random_points(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 100 == 0) begin
                drain_pipe();
                case ((k / 100) % 4)
                    0: begin
                        write_reg(REG_POS_X, '0);
                        write_reg(REG_POS_Y, '0);
                        write_reg(REG_POS_Z, 54'(32'sh0005_0000));
                        write_reg(REG_BASIS_U, pack_basis(-65536, 0, 0));
                        write_reg(REG_BASIS_V, pack_basis(0, 65536, 0));
                        write_reg(REG_BASIS_N, pack_basis(0, 0, 65536));
                        write_reg(REG_FOCAL_DEPTH, 54'($urandom_range(32'h0400_0000, 1)));
                        write_reg(REG_IMAGE_SIZE, 54'($urandom));
                    end
                    1: begin
                        write_reg(REG_POS_X, 54'($signed($urandom_range(1 << 22, 0)) - (1 << 21)));
                        write_reg(REG_POS_Y, 54'($signed($urandom_range(1 << 22, 0)) - (1 << 21)));
                        write_reg(REG_POS_Z, 54'($urandom_range(1 << 22, 0)));
                        write_reg(REG_BASIS_U, pack_basis($urandom_range(65536, 0) - 32768,
                                                          0, $urandom_range(65536, 0) - 32768));
                        write_reg(REG_BASIS_V, pack_basis(0, 65536, 0));
                        write_reg(REG_BASIS_N, pack_basis($urandom_range(65536, 0) - 32768,
                                                          0, $urandom_range(65536, 0)));
                        write_reg(REG_FOCAL_DEPTH, 54'($urandom));
                    end
                    default: begin
                        write_reg(REG_POS_X, 54'(rand_word()));
                        write_reg(REG_POS_Y, 54'(rand_word()));
                        write_reg(REG_POS_Z, 54'(rand_word()));
                        write_reg(REG_BASIS_U, CFG_W'({$urandom, $urandom}));
                        write_reg(REG_BASIS_V, CFG_W'({$urandom, $urandom}));
                        write_reg(REG_BASIS_N, CFG_W'({$urandom, $urandom}));
                        write_reg(REG_FOCAL_DEPTH, 54'(rand_word()));
                        write_reg(REG_IMAGE_SIZE, 54'($urandom));
                    end
                endcase
            end
            if (k < count / 3)             gap_pct = 21;
            else if (k < 2 * count / 3)    gap_pct = 66;
            else                           gap_pct = 0;
            if (k == count / 2) drain_pipe();
            send_point(rand_point($urandom_range(3, 0) != 0));
        end
        drain_pipe();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_point    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_POS_X;
        i_cfg_data <= '0;
        cam_pos_x  = '0;
        cam_pos_y  = '0;
        cam_pos_z  = RST_POS_Z;
        cam_u      = RST_BASIS_U;
        cam_v      = RST_BASIS_V;
        cam_n      = RST_BASIS_N;
        cam_focal  = RST_FOCAL;
        cam_size   = RST_IMAGE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_camera();
        test_extreme_camera();
        test_random_points(1000);

        $display("covered %0d points, %0d results checked, %0d behind the camera",
                 n_sent, n_checked, n_behind);
        if (n_errors == 0 && screens_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/wtsp_pkg.sv
design/wtsp_camera.sv
design/wtsp_divider.sv
design/wtsp_screen.sv
design/world_to_screen_projection.sv
design/wtsp_checker.sv
sim/testbench.sv
